[sv/tsgq_pkg.sv]
// tsgq_pkg: shared types, constants and helpers for the glyph quad generator
// used by tsgq_front, tsgq_queue, tsgq_back and the top level; no dependencies
package tsgq_pkg;

  localparam int GLYPH_W   = 8;
  localparam int GLYPH_H   = 8;
  localparam int SCALE_MAX = 16;
  localparam int ADV_W     = $clog2(GLYPH_W * SCALE_MAX + 1);
  localparam int HGT_W     = $clog2(GLYPH_H * SCALE_MAX + 1);

  localparam int QDEPTH = 2;  // power of two, pointers wrap by truncation
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_DW = 5;

  localparam logic [7:0] CODE_SPACE    = 8'd32;
  localparam logic [7:0] CODE_NEWLINE  = 8'd10;
  localparam logic [7:0] CODE_NOSHADOW = 8'h83;
  localparam logic [7:0] CODE_HIGH     = 8'h80;
  localparam logic [6:0] LOW7_MASK     = 7'd127;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_CHAR   = 2'd1,
    ACT_FINISH = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CFG_SCALE  = 2'd0,
    CFG_SHADOW = 2'd1,
    CFG_GAP    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [3:0]         style_flags;
    logic [31:0]        draw_color;
    logic [7:0]         char_code;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] quad_x;
    logic signed [15:0] quad_y;
    logic [7:0]         quad_w;
    logic [7:0]         quad_h;
    logic [3:0]         glyph_col;
    logic [3:0]         glyph_row;
    logic [31:0]        quad_color;
    logic               last;
  } out_item_t;

  // one queued job: a glyph with up to two shadows, or a cursor report
  typedef struct packed {
    logic               report;
    logic [1:0]         nshadow;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         w;
    logic [7:0]         h;
    logic [7:0]         code;
    logic [31:0]        color;
  } desc_t;

  typedef struct packed {
    logic  head_valid;
    desc_t head;
  } q_head_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

[sv/text_string_glyph_quad_generator_core.sv]
// channel | dir | handshake             | payload
// in      | in  | in_valid / in_ready   | in_data (in_item_t)
// out     | out | out_valid / out_ready | out_data (out_item_t)
// cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
// front takes one item per cycle while the job fifo has room; the back emits
// one quad per cycle unless stalled: a glyph and up to two shadows per character
// a quad is registered in the output register once its job is at the fifo head
// sync active-low reset clears cursor state, fifo and out_valid; presets config
// a stalled output holds its register; the front keeps accepting until the
// fifo fills; start, space and multiline newline items need no back cycles
module text_string_glyph_quad_generator_core import tsgq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  logic    q_full;
  logic    q_push;
  logic    q_pop;
  desc_t   q_wdata;
  q_head_t q_hd;

  tsgq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  tsgq_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .hd    (q_hd)
  );

  tsgq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .hd        (q_hd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[sv/tsgq_front.sv]
// tsgq_front: accepts items, holds config and cursor state, builds queue jobs
// depends on tsgq_pkg
module tsgq_front import tsgq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_DW-1:0]  cfg_data,
  input  logic               q_full,
  output logic               q_push,
  output desc_t              q_wdata
);

  logic [4:0]         scale_r, scale_nxt;
  logic [1:0]         shlvl_r, shlvl_nxt;
  logic [3:0]         gap_r, gap_nxt;
  logic signed [15:0] cursor_x_r, cursor_x_nxt;
  logic signed [15:0] cursor_y_r, cursor_y_nxt;
  logic signed [15:0] line_x_r, line_x_nxt;
  logic [3:0]         flags_r, flags_nxt;
  logic [31:0]        color_r, color_nxt;

  logic [4:0]       scale_eff;
  logic [ADV_W-1:0] adv;
  logic [HGT_W-1:0] hgt;
  logic [7:0]       qw, qh;
  logic [7:0]       code_f;
  logic             shadow_en;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  always_comb begin
    scale_eff = scale_r;
    if (scale_r == 5'd0) begin
      scale_eff = 5'd1;
    end else if (int'(scale_r) > SCALE_MAX) begin
      scale_eff = 5'(SCALE_MAX);
    end
    adv = ADV_W'(GLYPH_W * int'(scale_eff));
    hgt = HGT_W'(GLYPH_H * int'(scale_eff));
    qw  = (int'(adv) > 255) ? 8'hFF : 8'(adv);
    qh  = (int'(hgt) > 255) ? 8'hFF : 8'(hgt);

    code_f = in_data.char_code;
    if (flags_r[1]) begin
      code_f = code_f | CODE_HIGH;
    end
    if (flags_r[2]) begin
      code_f = code_f ^ CODE_HIGH;
    end
    shadow_en = flags_r[3] || (shlvl_r != 2'd0);
  end

  always_comb begin
    scale_nxt    = scale_r;
    shlvl_nxt    = shlvl_r;
    gap_nxt      = gap_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    line_x_nxt   = line_x_r;
    flags_nxt    = flags_r;
    color_nxt    = color_r;
    q_push       = 1'b0;

    q_wdata         = '0;
    q_wdata.x       = cursor_x_r;
    q_wdata.y       = cursor_y_r;
    q_wdata.w       = qw;
    q_wdata.h       = qh;
    q_wdata.code    = code_f;
    q_wdata.color   = code_f[7] ? {color_r[31:24], 24'hFFFFFF} : color_r;
    q_wdata.nshadow = 2'd0;
    if (shadow_en && code_f != CODE_NOSHADOW) begin
      q_wdata.nshadow = (shlvl_r > 2'd1) ? 2'd2 : 2'd1;
    end

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCALE:  scale_nxt = cfg_data;
        CFG_SHADOW: shlvl_nxt = cfg_data[1:0];
        CFG_GAP:    gap_nxt   = cfg_data[3:0];
        default:    ;
      endcase
    end

    if (accept) begin
      case (in_data.action)
        ACT_START: begin
          cursor_x_nxt = in_data.start_x;
          cursor_y_nxt = in_data.start_y;
          line_x_nxt   = in_data.start_x;
          flags_nxt    = in_data.style_flags;
          color_nxt    = in_data.draw_color;
        end
        ACT_CHAR: begin
          if (flags_r[0] && in_data.char_code == CODE_NEWLINE) begin
            cursor_y_nxt = sat16(18'(cursor_y_r) + 18'(signed'({1'b0, hgt}))
                                 + 18'(signed'({1'b0, gap_r})));
            cursor_x_nxt = line_x_r;
          end else begin
            q_push       = (in_data.char_code[6:0] != CODE_SPACE[6:0]);
            cursor_x_nxt = sat16(18'(cursor_x_r) + 18'(signed'({1'b0, adv})));
          end
        end
        ACT_FINISH: begin
          q_push  = 1'b1;
          q_wdata = '0;
          q_wdata.report = 1'b1;
          q_wdata.x      = cursor_x_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= 5'd1;
      shlvl_r    <= 2'd0;
      gap_r      <= 4'd1;
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      line_x_r   <= '0;
      flags_r    <= '0;
      color_r    <= '0;
    end else begin
      scale_r    <= scale_nxt;
      shlvl_r    <= shlvl_nxt;
      gap_r      <= gap_nxt;
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      line_x_r   <= line_x_nxt;
      flags_r    <= flags_nxt;
      color_r    <= color_nxt;
    end
  end

endmodule

[sv/tsgq_queue.sv]
// tsgq_queue: small job fifo between front and back
// depends on tsgq_pkg
module tsgq_queue import tsgq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  desc_t   wdata,
  output logic    full,
  input  logic    pop,
  output q_head_t hd
);

  desc_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full          = (int'(cnt_r) == QDEPTH);
  assign hd.head_valid = (cnt_r != '0);
  assign hd.head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(int'(wr_ptr_r) + 1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QPTR_W'(int'(rd_ptr_r) + 1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = QCNT_W'(int'(cnt_r) + 1);
    end else if (pop && !push) begin
      cnt_nxt = QCNT_W'(int'(cnt_r) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[sv/tsgq_back.sv]
// tsgq_back: expands queued jobs into shadow, glyph and cursor report quads,
// one per cycle unless the output stalls; depends on tsgq_pkg
module tsgq_back import tsgq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   hd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [1:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;
  logic       load;
  logic       final_step;
  logic [1:0] offs;

  assign load       = hd.head_valid && (!out_valid_r || out_ready);
  assign final_step = (step_r == hd.head.nshadow);
  assign q_pop      = load && final_step;
  assign offs       = step_r + 2'd1;

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt      = 1'b1;
      step_nxt           = final_step ? 2'd0 : step_r + 2'd1;
      out_nxt.kind       = hd.head.report;
      out_nxt.quad_w     = hd.head.w;
      out_nxt.quad_h     = hd.head.h;
      out_nxt.glyph_col  = hd.head.code[3:0];
      out_nxt.glyph_row  = hd.head.code[7:4];
      out_nxt.last       = final_step;
      if (final_step) begin
        out_nxt.quad_x     = hd.head.x;
        out_nxt.quad_y     = hd.head.y;
        out_nxt.quad_color = hd.head.color;
      end else begin
        // shadow copies sit one or two pixels down and right, black with alpha
        out_nxt.quad_x     = sat16(18'(hd.head.x) + 18'(signed'({1'b0, offs})));
        out_nxt.quad_y     = sat16(18'(hd.head.y) + 18'(signed'({1'b0, offs})));
        out_nxt.quad_color = {hd.head.color[31:24], 24'h000000};
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_report_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind) |-> out_r.last)
    else $error("cursor report without last");

  a_step_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != 2'd0) |-> hd.head_valid)
    else $error("mid-job step with empty queue");

  a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    hd.head_valid |-> (step_r <= hd.head.nshadow))
    else $error("step beyond shadow count");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid_r && out_r.last))
    else $error("job retired without last result");
`endif

endmodule

[bench/tb_text_string_glyph_quad_generator_core.sv]
// testbench for text_string_glyph_quad_generator_core: directed strings, then random
// strings under several register settings, checked by a quad scoreboard class
// depends on tsgq_pkg and the core RTL only
module tb_text_string_glyph_quad_generator_core import tsgq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  ACT_UNUSED    = 2'd3;
  localparam logic [3:0]  FLAG_MULTI    = 4'b0001;
  localparam logic [3:0]  FLAG_ALT      = 4'b0010;
  localparam logic [3:0]  FLAG_XOR      = 4'b0100;
  localparam logic [3:0]  FLAG_SHADOW   = 4'b1000;
  localparam logic [31:0] WHITE_RGB     = 32'h00FF_FFFF;
  localparam logic [31:0] ALPHA_MASK    = 32'hFF00_0000;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          PHASE_ITEMS   = 20;

  class quad_scoreboard;
    logic signed [15:0] cur_x, cur_y, line_x;
    logic [3:0]         flags;
    logic [31:0]        color;
    int                 scale_reg, shadow_reg, gap_reg;
    out_item_t          quads_due[$];
    int                 fails;

    function new();
      cur_x = '0;
      cur_y = '0;
      line_x = '0;
      flags = '0;
      color = '0;
      scale_reg = 1;
      shadow_reg = 0;
      gap_reg = 1;
      fails = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [4:0] val);
      case (idx)
        CFG_SCALE:  scale_reg = int'(val);
        CFG_SHADOW: shadow_reg = int'(val[1:0]);
        CFG_GAP:    gap_reg = int'(val[3:0]);
        default: ;
      endcase
    endfunction

    function logic signed [15:0] clamp16(int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    function void push_quad(logic signed [15:0] x, logic signed [15:0] y, int w, int h,
                            logic [7:0] code, logic [31:0] col, logic fin);
      out_item_t q;
      q.kind = 1'b0;
      q.quad_x = x;
      q.quad_y = y;
      q.quad_w = (w > 255) ? 8'd255 : w[7:0];
      q.quad_h = (h > 255) ? 8'd255 : h[7:0];
      q.glyph_col = code[3:0];
      q.glyph_row = code[7:4];
      q.quad_color = col;
      q.last = fin;
      quads_due.push_back(q);
    endfunction

    // works out the quads that one accepted transfer causes
    function void take_item(in_item_t it);
      out_item_t   q;
      logic [7:0]  code;
      logic [31:0] alpha;
      int          eff, adv, hgt;
      bit          shade;
      case (it.action)
        ACT_START: begin
          cur_x = it.start_x;
          cur_y = it.start_y;
          line_x = it.start_x;
          flags = it.style_flags;
          color = it.draw_color;
        end
        ACT_FINISH: begin
          q = '0;
          q.kind = 1'b1;
          q.quad_x = cur_x;
          q.last = 1'b1;
          quads_due.push_back(q);
        end
        ACT_CHAR: begin
          eff = (scale_reg == 0) ? 1 : (scale_reg > 16) ? 16 : scale_reg;
          adv = GLYPH_W * eff;
          hgt = GLYPH_H * eff;
          shade = ((flags & FLAG_SHADOW) != 0) || (shadow_reg > 0);
          if (((flags & FLAG_MULTI) != 0) && it.char_code == CODE_NEWLINE) begin
            cur_y = clamp16(cur_y + hgt + gap_reg);
            cur_x = line_x;
          end else begin
            if ((it.char_code & {1'b0, LOW7_MASK}) != CODE_SPACE) begin
              code = it.char_code;
              if ((flags & FLAG_ALT) != 0) code = code | CODE_HIGH;
              if ((flags & FLAG_XOR) != 0) code = code ^ CODE_HIGH;
              alpha = color & ALPHA_MASK;
              if (shade && code != CODE_NOSHADOW) begin
                push_quad(clamp16(cur_x + 1), clamp16(cur_y + 1), adv, hgt, code, alpha, 1'b0);
                if (shadow_reg > 1)
                  push_quad(clamp16(cur_x + 2), clamp16(cur_y + 2), adv, hgt, code, alpha, 1'b0);
              end
              push_quad(cur_x, cur_y, adv, hgt, code,
                        ((code & CODE_HIGH) != 0) ? (alpha | WHITE_RGB) : color, 1'b1);
            end
            cur_x = clamp16(cur_x + adv);
          end
        end
        default: ;
      endcase
    endfunction

    function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
        fails++;
      end
    endfunction

    function void check_quad(out_item_t got);
      out_item_t want;
      if (quads_due.size() == 0) begin
        $error("quad with nothing outstanding: %p", got);
        fails++;
        return;
      end
      want = quads_due.pop_front();
      field("kind", want.kind, got.kind);
      field("quad_x", 16'(want.quad_x), 16'(got.quad_x));
      field("quad_y", 16'(want.quad_y), 16'(got.quad_y));
      field("quad_w", want.quad_w, got.quad_w);
      field("quad_h", want.quad_h, got.quad_h);
      field("glyph_col", want.glyph_col, got.glyph_col);
      field("glyph_row", want.glyph_row, got.glyph_row);
      field("quad_color", want.quad_color, got.quad_color);
      field("last", want.last, got.last);
    endfunction
  endclass

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  quad_scoreboard sb = new();
  int             burst_left = 0;
  int             rx_mode = 0;
  int             rx_left = 0;
  int             cycle_count = 0;

  text_string_glyph_quad_generator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: check each transfer, stall in modes of random length
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_quad(out_data);
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(8, 60);
    end
    rx_left--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= rx_left[2];
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [1:0] act, logic [15:0] x, logic [15:0] y,
                                         logic [3:0] fl, logic [31:0] col, logic [7:0] code);
    in_item_t it;
    it.action = act;
    it.start_x = x;
    it.start_y = y;
    it.style_flags = fl;
    it.draw_color = col;
    it.char_code = code;
    return it;
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return 8'($urandom_range(33, 126));
    case (r)
      8, 9:   return CODE_SPACE;
      10:     return CODE_SPACE | CODE_HIGH;
      11, 12: return CODE_NEWLINE;
      13:     return CODE_NOSHADOW;
      14:     return CODE_NOSHADOW ^ CODE_HIGH;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_pos();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'(32767 - $urandom_range(0, 200));
      2: return 16'($urandom_range(0, 500));
      default: return 16'(-32768 + int'($urandom_range(0, 200)));
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_item(it);
    burst_left--;
  endtask

  // stop sending and wait out every outstanding quad plus pipeline slack
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.quads_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_strings(int budget);
    int         sent;
    int         nchar;
    logic [1:0] act;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 8) begin
        send_item(make_item(ACT_START, pick_pos(), pick_pos(), 4'($urandom), $urandom,
                            8'($urandom)));
        nchar = $urandom_range(1, 8);
        repeat (nchar)
          send_item(make_item(ACT_CHAR, 16'($urandom), 16'($urandom), 4'($urandom), $urandom,
                              pick_code()));
        send_item(make_item(ACT_FINISH, 16'($urandom), 16'($urandom), 4'($urandom), $urandom,
                            8'($urandom)));
        sent += nchar + 2;
      end else begin
        // noise: lone items of any action, unused action included
        act = 2'($urandom_range(0, 3));
        send_item(make_item(act, pick_pos(), pick_pos(), 4'($urandom), $urandom, pick_code()));
        if (act != ACT_UNUSED) sent++;
      end
    end
  endtask

  task automatic run_phase(logic [4:0] scale, logic [1:0] shadow, logic [3:0] gap);
    settle();
    write_reg(CFG_SCALE, scale);
    write_reg(CFG_SHADOW, 5'(shadow));
    write_reg(CFG_GAP, 5'(gap));
    random_strings(PHASE_ITEMS);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings under the reset register values
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, "A"));
    send_item(make_item(ACT_FINISH, 16'h0, 16'h0, 4'h0, 32'h0, 8'h0));
    send_item(make_item(ACT_START, 16'h8000, 16'h8000, 4'h0, 32'h0, 8'h0));
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, 8'h00));
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, 8'hFF));
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, CODE_SPACE));
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, CODE_SPACE | CODE_HIGH));
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, CODE_NEWLINE));
    send_item(make_item(ACT_FINISH, 16'h0, 16'h0, 4'h0, 32'h0, 8'h0));
    // saturation at the top edge with multiline and drop shadow
    send_item(make_item(ACT_START, 16'd32760, 16'h7FFF, FLAG_MULTI | FLAG_SHADOW,
                        32'h8012_3456, 8'h0));
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, "A"));
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, CODE_NOSHADOW));
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, "B"));
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, CODE_NEWLINE));
    send_item(make_item(ACT_FINISH, 16'h0, 16'h0, 4'h0, 32'h0, 8'h0));
    send_item(make_item(ACT_START, 16'd100, 16'd50, FLAG_ALT, 32'h1122_3344, 8'h0));
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, CODE_NOSHADOW ^ CODE_HIGH));
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, "a"));
    send_item(make_item(ACT_START, 16'd7, 16'hFFF0, 4'hF, 32'hA5A5_A5A5, 8'h0));
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, CODE_NOSHADOW ^ CODE_HIGH));
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, CODE_NOSHADOW));
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, CODE_NEWLINE));
    send_item(make_item(ACT_CHAR, 16'h0, 16'h0, 4'h0, 32'h0, "z"));
    send_item(make_item(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 4'hF, 32'hFFFF_FFFF, 8'hFF));
    send_item(make_item(ACT_FINISH, 16'h0, 16'h0, 4'h0, 32'h0, 8'h0));

    // random strings across register settings, extremes and out-of-range values included
    run_phase(5'd2, 2'd1, 4'd0);
    run_phase(5'd16, 2'd2, 4'd15);
    run_phase(5'd0, 2'd3, 4'd7);
    run_phase(5'd17, 2'd0, 4'd3);
    run_phase(5'd31, 2'd2, 4'd15);
    run_phase(5'd1, 2'd1, 4'd0);

    settle();
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
